// File: sv/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg
// Shared types and codes for the bounded ordered list engine.
// ----------------------------------------------------------------------------
package bole_pkg;

    // Command codes carried by each request.
    typedef enum logic [2:0] {
        CMD_TRAVERSE = 3'd0,
        CMD_INS_HEAD = 3'd1,
        CMD_INS_TAIL = 3'd2,
        CMD_INS_AT   = 3'd3,
        CMD_SEARCH   = 3'd4,
        CMD_DELETE   = 3'd5
    } t_cmd;

    // Status codes of a result.
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_EMPTY    = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

    localparam int unsigned VAL_W = 32;
    localparam int unsigned POS_W = 6;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;         // capture the accepted request
        logic edit;         // apply an edit and emit its status
        logic step;         // rotate the used cells by one place
        logic emit_search;  // emit the search outcome
        logic emit_empty;   // emit the empty result of a traverse
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;     // output register can take a result this cycle
        logic walk_done;    // every stored entry has been visited
        logic count_zero;   // list holds nothing
        logic last_step;    // the next step visits the final entry
    } t_dp_stat;

endpackage

// File: sv/bole_if.sv
// ----------------------------------------------------------------------------
// bole_if
// Request and result channels of the bounded ordered list engine.
// ----------------------------------------------------------------------------
interface bole_in_if;
    logic                         valid;
    logic                         ready;
    logic [2:0]                   command;
    logic signed [31:0]           value;
    logic [5:0]                   position;

    modport source (output valid, output command, output value, output position,
                    input ready);
    modport sink   (input valid, input command, input value, input position,
                    output ready);
endinterface

interface bole_out_if;
    logic                         valid;
    logic                         ready;
    logic signed [31:0]           value_res;
    logic [5:0]                   position_res;
    logic [2:0]                   status;
    logic                         last;

    modport source (output valid, output value_res, output position_res,
                    output status, output last, input ready);
    modport sink   (input valid, input value_res, input position_res,
                    input status, input last, output ready);
endinterface

// File: sv/bole_ctrl.sv
// ----------------------------------------------------------------------------
// bole_ctrl
// Controller: sequences edits, searches and traversals over the cell bank.
// ----------------------------------------------------------------------------
module bole_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [2:0]        i_command,
    output logic              o_ready,
    input  bole_pkg::t_dp_stat i_stat,
    output bole_pkg::t_dp_cmd  o_cmd
);
    import bole_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EDIT,
        S_WALK
    } t_state;

    t_state r_state, n_state;
    logic   r_is_trav, n_is_trav;
    logic   accepted;

    assign o_ready  = (r_state == S_IDLE);
    assign accepted = i_valid && o_ready;

    // Next state and datapath commands.
    always_comb begin
        n_state   = r_state;
        n_is_trav = r_is_trav;
        o_cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (accepted) begin
                    o_cmd.load = 1'b1;
                    case (i_command)
                        CMD_TRAVERSE: begin
                            n_state   = S_WALK;
                            n_is_trav = 1'b1;
                        end
                        CMD_SEARCH: begin
                            n_state   = S_WALK;
                            n_is_trav = 1'b0;
                        end
                        CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT, CMD_DELETE: begin
                            n_state = S_EDIT;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_EDIT: begin
                if (i_stat.out_free) begin
                    o_cmd.edit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_WALK: begin
                if (r_is_trav) begin
                    if (i_stat.out_free) begin
                        if (i_stat.count_zero) begin
                            o_cmd.emit_empty = 1'b1;
                            n_state          = S_IDLE;
                        end else begin
                            o_cmd.step = 1'b1;
                            if (i_stat.last_step) begin
                                n_state = S_IDLE;
                            end
                        end
                    end
                end else if (!i_stat.walk_done) begin
                    o_cmd.step = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.emit_search = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_is_trav <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_trav <= n_is_trav;
        end
    end

    // Checks.
    a_edit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.edit || o_cmd.emit_search || o_cmd.emit_empty) |-> i_stat.out_free)
        else $error("result issued while output register is occupied");
    a_trav_step_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.step && r_is_trav) |-> i_stat.out_free)
        else $error("traverse step without room for its result");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state != S_IDLE) || !$past(i_command <= CMD_DELETE))
        else $error("valid request left the controller idle");

endmodule

// File: sv/bole_dpath.sv
// ----------------------------------------------------------------------------
// bole_dpath
// Datapath: bank of shifting cells, entry count, walk index and result register.
// ----------------------------------------------------------------------------
module bole_dpath #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [2:0]         i_command,
    input  logic signed [31:0] i_value,
    input  logic [5:0]         i_position,
    input  bole_pkg::t_dp_cmd  i_cmd,
    output bole_pkg::t_dp_stat o_stat,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_value_res,
    output logic [5:0]         o_position_res,
    output logic [2:0]         o_status,
    output logic               o_last
);
    import bole_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned PW = (CW + 1 > POS_W) ? CW + 1 : POS_W;

    logic [VAL_W-1:0] r_cells [CAPACITY];
    logic [VAL_W-1:0] n_cells [CAPACITY];
    logic [VAL_W-1:0] prv     [CAPACITY];
    logic [VAL_W-1:0] nxt     [CAPACITY];

    logic [CW-1:0]    r_count, n_count;
    logic [CW-1:0]    r_idx;
    logic [CW-1:0]    r_found;
    logic             r_hit;
    t_cmd             r_cmd;
    logic [VAL_W-1:0] r_val;
    logic [POS_W-1:0] r_pos;

    logic             r_out_valid;
    logic [VAL_W-1:0] r_out_value;
    logic [POS_W-1:0] r_out_pos;
    t_status          r_out_status;
    logic             r_out_last;

    logic [PW-1:0]    cnt_w, pos_w, tgt, slot, idx_w;
    logic             full, ins_bad, del_bad, is_del, ins_ok, del_ok;
    t_status          edit_st;

    // Neighbour taps of each cell.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_taps
        if (g == 0) begin : g_first
            assign prv[g] = '0;
        end else begin : g_prev
            assign prv[g] = r_cells[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign nxt[g] = r_cells[0];
        end else begin : g_next
            assign nxt[g] = r_cells[g+1];
        end
    end

    // Edit decode and status.
    always_comb begin
        cnt_w  = PW'(r_count);
        pos_w  = PW'(r_pos);
        idx_w  = PW'(r_idx);
        is_del = (r_cmd == CMD_DELETE);
        case (r_cmd)
            CMD_INS_HEAD: tgt = PW'(1);
            CMD_INS_TAIL: tgt = cnt_w + PW'(1);
            default:      tgt = pos_w;
        endcase
        full    = (r_count == CW'(CAPACITY));
        ins_bad = (tgt == '0) || (tgt > cnt_w + PW'(1));
        del_bad = (pos_w == '0) || (pos_w > cnt_w);
        if (is_del) begin
            edit_st = (r_count == '0) ? ST_EMPTY : (del_bad ? ST_BADPOS : ST_OK);
        end else begin
            edit_st = full ? ST_FULL : (ins_bad ? ST_BADPOS : ST_OK);
        end
        ins_ok = i_cmd.edit && !is_del && !full && !ins_bad;
        del_ok = i_cmd.edit && is_del && (r_count != '0) && !del_bad;
        slot   = (is_del ? pos_w : tgt) - PW'(1);
        n_count = r_count;
        if (ins_ok) begin
            n_count = r_count + CW'(1);
        end else if (del_ok) begin
            n_count = r_count - CW'(1);
        end
    end

    // Per-cell next value: shift for edits, rotate the used cells for walks.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            n_cells[i] = r_cells[i];
            if (ins_ok) begin
                if (PW'(i) == slot) begin
                    n_cells[i] = r_val;
                end else if (PW'(i) > slot && PW'(i) <= cnt_w) begin
                    n_cells[i] = prv[i];
                end
            end else if (del_ok) begin
                if (PW'(i) >= slot && PW'(i) + PW'(1) < cnt_w) begin
                    n_cells[i] = nxt[i];
                end
            end else if (i_cmd.step) begin
                if (PW'(i) + PW'(1) < cnt_w) begin
                    n_cells[i] = nxt[i];
                end else if (PW'(i) + PW'(1) == cnt_w) begin
                    n_cells[i] = r_cells[0];
                end
            end
        end
    end

    // Cell bank and captured request.
    always_ff @(posedge i_clk) begin
        r_cells <= n_cells;
        if (i_cmd.load) begin
            r_cmd <= t_cmd'(i_command);
            r_val <= i_value;
            r_pos <= i_position;
        end
    end

    // Count, walk index and search match.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
            r_hit   <= 1'b0;
            r_found <= '0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else if (i_cmd.step) begin
                r_idx <= r_idx + CW'(1);
                if (!r_hit && r_cells[0] == r_val) begin
                    r_hit   <= 1'b1;
                    r_found <= r_idx + CW'(1);
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.edit || i_cmd.emit_search || i_cmd.emit_empty
                     || (i_cmd.step && r_cmd == CMD_TRAVERSE)) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.edit) begin
            r_out_value  <= '0;
            r_out_pos    <= '0;
            r_out_status <= edit_st;
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit_empty) begin
            r_out_value  <= '0;
            r_out_pos    <= '0;
            r_out_status <= ST_EMPTY;
            r_out_last   <= 1'b1;
        end else if (i_cmd.emit_search) begin
            r_out_value  <= '0;
            r_out_pos    <= r_hit ? POS_W'(PW'(r_found)) : '0;
            r_out_status <= r_hit ? ST_OK : ST_NOTFOUND;
            r_out_last   <= 1'b1;
        end else if (i_cmd.step && r_cmd == CMD_TRAVERSE) begin
            r_out_value  <= r_cells[0];
            r_out_pos    <= POS_W'(idx_w + PW'(1));
            r_out_status <= ST_OK;
            r_out_last   <= (idx_w + PW'(1) == cnt_w);
        end
    end

    assign o_valid        = r_out_valid;
    assign o_value_res    = r_out_value;
    assign o_position_res = r_out_pos;
    assign o_status       = r_out_status;
    assign o_last         = r_out_last;

    assign o_stat.out_free   = !r_out_valid || i_ready;
    assign o_stat.walk_done  = (r_idx == r_count);
    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.last_step  = (idx_w + PW'(1) == cnt_w);

    // Checks.
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        PW'(r_count) <= PW'(CAPACITY))
        else $error("entry count above capacity");
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_idx < r_count))
        else $error("walk stepped past the last entry");
    a_count_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |=> $stable(r_count))
        else $error("entry count changed during a walk");

endmodule

// File: sv/bounded_ordered_list_engine_unit.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine_unit
// Ordered list of signed 32-bit values held in a bank of shifting cells.
//
//   Channel  Direction  Carries
//   i_in     in         command, value, position
//   o_out    out        value_res, position_res, status, last
//
// An edit captures the request, then shifts the cells and issues its status.
// A search or a traverse rotates the used cells past cell zero one place per
// cycle, a traverse only while the result register is free.
// Synchronous active-low reset empties the list; cell contents are not reset.
// A full result register stalls an edit, a traverse step or the search result until it is taken.
// ----------------------------------------------------------------------------
module bounded_ordered_list_engine_unit #(
    parameter int unsigned CAPACITY = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bole_in_if.sink    i_in,
    bole_out_if.source o_out
);
    import bole_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencing of each request.
    bole_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in.valid),
        .i_command (i_in.command),
        .o_ready   (i_in.ready),
        .i_stat    (dp_stat),
        .o_cmd     (dp_cmd)
    );

    // Cells, count and result register.
    bole_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_command      (i_in.command),
        .i_value        (i_in.value),
        .i_position     (i_in.position),
        .i_cmd          (dp_cmd),
        .o_stat         (dp_stat),
        .o_valid        (o_out.valid),
        .i_ready        (o_out.ready),
        .o_value_res    (o_out.value_res),
        .o_position_res (o_out.position_res),
        .o_status       (o_out.status),
        .o_last         (o_out.last)
    );

endmodule
